[src/lzwd_pkg.sv]
package lzwd_pkg;

    localparam int WINDOW_DEPTH_DEF = 4096;
    localparam int DIST_BIAS        = 4;
    localparam int LEN_BIAS         = 2;
    localparam int DIST_W           = 12;
    localparam int LEN_W            = 5;
    localparam int BLOCKS_W         = 32;
    localparam int LIT_W            = 7;

    typedef struct packed {
        logic       hdr_we;
        logic [1:0] hdr_idx;
        logic       lit_load;
        logic       lit_store;
        logic       mhi_load;
        logic       copy_start;
        logic       copy_run;
        logic       emit_end;
        logic       blk_dec;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic hdr_zero;
        logic last_block;
        logic tok_lit;
        logic tok_empty;
        logic lit_one;
        logic copy_done;
    } status_t;

endpackage

[src/lzwd_ram.sv]
module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/lzwd_ctrl.sv]
module lzwd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  lzwd_pkg::status_t status,
    output lzwd_pkg::cmd_t    cmd
);
    import lzwd_pkg::*;

    localparam logic [2:0] ST_HDR0  = 3'd0;
    localparam logic [2:0] ST_HDR1  = 3'd1;
    localparam logic [2:0] ST_HDR2  = 3'd2;
    localparam logic [2:0] ST_HDR3  = 3'd3;
    localparam logic [2:0] ST_TOKEN = 3'd4;
    localparam logic [2:0] ST_LIT   = 3'd5;
    localparam logic [2:0] ST_MLO   = 3'd6;
    localparam logic [2:0] ST_COPY  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign s_tready = status.out_free && (state_reg != ST_COPY);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_HDR1, ST_HDR2: begin
                if (accept) begin
                    cmd.hdr_we  = 1'b1;
                    cmd.hdr_idx = state_reg[1:0];
                    state_next  = state_reg + 3'd1;
                end
            end
            ST_HDR3: begin
                if (accept) begin
                    cmd.hdr_we  = 1'b1;
                    cmd.hdr_idx = state_reg[1:0];
                    if (status.hdr_zero) begin
                        cmd.emit_end = 1'b1;
                        state_next   = ST_HDR0;
                    end else begin
                        state_next = ST_TOKEN;
                    end
                end
            end
            ST_TOKEN: begin
                if (accept) begin
                    if (status.tok_lit) begin
                        cmd.lit_load = 1'b1;
                        if (status.tok_empty) begin
                            cmd.blk_dec = 1'b1;
                            if (status.last_block) begin
                                cmd.emit_end = 1'b1;
                                state_next   = ST_HDR0;
                            end
                        end else begin
                            state_next = ST_LIT;
                        end
                    end else begin
                        cmd.mhi_load = 1'b1;
                        state_next   = ST_MLO;
                    end
                end
            end
            ST_LIT: begin
                if (accept) begin
                    cmd.lit_store = 1'b1;
                    if (status.lit_one) begin
                        cmd.blk_dec = 1'b1;
                        state_next  = status.last_block ? ST_HDR0 : ST_TOKEN;
                    end
                end
            end
            ST_MLO: begin
                if (accept) begin
                    cmd.copy_start = 1'b1;
                    state_next     = ST_COPY;
                end
            end
            ST_COPY: begin
                cmd.copy_run = 1'b1;
                if (status.copy_done) begin
                    cmd.blk_dec = 1'b1;
                    state_next  = status.last_block ? ST_HDR0 : ST_TOKEN;
                end
            end
            default: begin
                if (accept) begin
                    cmd.hdr_we  = 1'b1;
                    cmd.hdr_idx = 2'd0;
                    state_next  = ST_HDR1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HDR0;
        end else begin
            state_reg <= state_next;
        end
    end

    a_copy_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COPY && status.copy_done)
        |=> (state_reg == ST_HDR0 || state_reg == ST_TOKEN))
        else $error("copy did not return to parsing");

    a_copy_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.copy_start |=> state_reg == ST_COPY)
        else $error("match low byte did not start a copy");

    a_copy_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COPY) |-> !s_tready)
        else $error("input accepted during a copy");

endmodule

[src/lzwd_datapath.sv]
module lzwd_datapath #(
    parameter int WINDOW_DEPTH = lzwd_pkg::WINDOW_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [7:0]        in_byte,
    input  lzwd_pkg::cmd_t    cmd,
    output lzwd_pkg::status_t status,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_data,
    output logic              m_byte_valid,
    output logic              m_run_last,
    output logic              m_stream_end
);
    import lzwd_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);

    logic [BLOCKS_W-1:0] bl_reg,   bl_next;
    logic [LIT_W-1:0]    lit_reg,  lit_next;
    logic [7:0]          mhi_reg,  mhi_next;
    logic [AW-1:0]       wp_reg,   wp_next;
    logic [AW:0]         fill_reg, fill_next;
    logic [AW-1:0]       src_reg,  src_next;
    logic [LEN_W-1:0]    cnt_reg,  cnt_next;
    logic                pend_reg, pend_next;
    logic                rvalid_reg;
    logic                m_valid_reg, m_valid_next;
    logic [7:0]          m_data_reg;
    logic                m_bv_reg, m_last_reg, m_end_reg;

    logic                out_free;
    logic                copy_emit;
    logic                copy_last;
    logic [DIST_W-1:0]   match_dist;
    logic [AW:0]         diff;
    logic [AW:0]         diff_wrap;
    logic [AW-1:0]       src_start;
    logic [AW-1:0]       src_inc;
    logic [AW-1:0]       wp_inc;
    logic [7:0]          copy_byte;
    logic                mem_we, mem_re;
    logic [7:0]          mem_wdata, mem_rdata;
    logic                rd_hit;

    assign out_free  = !m_valid_reg || m_tready;
    assign copy_emit = cmd.copy_run && pend_reg && out_free;
    assign copy_last = cnt_reg == LEN_W'(1);

    assign match_dist = DIST_W'({mhi_reg[2:0], in_byte}) + DIST_W'(DIST_BIAS);
    assign diff      = {1'b0, wp_reg} - (AW+1)'(match_dist);
    assign diff_wrap = diff + (AW+1)'(WINDOW_DEPTH);
    assign src_start = diff[AW] ? diff_wrap[AW-1:0] : diff[AW-1:0];
    assign src_inc   = (src_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : src_reg + AW'(1);
    assign wp_inc    = (wp_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
    assign copy_byte = rvalid_reg ? mem_rdata : 8'd0;
    assign rd_hit    = {1'b0, src_reg} < fill_reg;

    assign mem_we    = cmd.lit_store || copy_emit;
    assign mem_wdata = cmd.lit_store ? in_byte : copy_byte;
    assign mem_re    = cmd.copy_run && (!pend_reg || (copy_emit && !copy_last));

    lzwd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (wp_reg),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (src_reg),
        .rdata (mem_rdata)
    );

    always_comb begin
        bl_next   = bl_reg;
        lit_next  = lit_reg;
        mhi_next  = mhi_reg;
        wp_next   = wp_reg;
        fill_next = fill_reg;
        src_next  = src_reg;
        cnt_next  = cnt_reg;
        pend_next = pend_reg;

        if (cmd.hdr_we) begin
            case (cmd.hdr_idx)
                2'd0:    bl_next = {24'd0, in_byte};
                2'd1:    bl_next[15:8]  = in_byte;
                2'd2:    bl_next[23:16] = in_byte;
                default: bl_next[31:24] = in_byte;
            endcase
        end
        if (cmd.blk_dec) begin
            bl_next = bl_reg - BLOCKS_W'(1);
        end
        if (cmd.lit_load) begin
            lit_next = in_byte[LIT_W-1:0];
        end
        if (cmd.lit_store) begin
            lit_next = lit_reg - LIT_W'(1);
        end
        if (cmd.mhi_load) begin
            mhi_next = in_byte;
        end
        if (cmd.copy_start) begin
            src_next  = src_start;
            cnt_next  = LEN_W'(mhi_reg[7:3]) + LEN_W'(LEN_BIAS);
            pend_next = 1'b0;
        end
        if (mem_re) begin
            src_next  = src_inc;
            pend_next = 1'b1;
        end
        if (copy_emit) begin
            cnt_next = cnt_reg - LEN_W'(1);
            if (copy_last) begin
                pend_next = 1'b0;
            end
        end
        if (mem_we) begin
            wp_next = wp_inc;
            if (fill_reg < (AW+1)'(WINDOW_DEPTH)) begin
                fill_next = fill_reg + (AW+1)'(1);
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        if (cmd.emit_end || cmd.lit_store || copy_emit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bl_reg      <= '0;
            lit_reg     <= '0;
            mhi_reg     <= '0;
            wp_reg      <= '0;
            fill_reg    <= '0;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            bl_reg      <= bl_next;
            lit_reg     <= lit_next;
            mhi_reg     <= mhi_next;
            wp_reg      <= wp_next;
            fill_reg    <= fill_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg <= src_next;
        if (mem_re) begin
            rvalid_reg <= rd_hit;
        end
        if (cmd.emit_end) begin
            m_data_reg <= 8'd0;
            m_bv_reg   <= 1'b0;
            m_last_reg <= 1'b1;
            m_end_reg  <= 1'b1;
        end else if (cmd.lit_store) begin
            m_data_reg <= in_byte;
            m_bv_reg   <= 1'b1;
            m_last_reg <= 1'b1;
            m_end_reg  <= status.lit_one && status.last_block;
        end else if (copy_emit) begin
            m_data_reg <= copy_byte;
            m_bv_reg   <= 1'b1;
            m_last_reg <= copy_last;
            m_end_reg  <= copy_last && status.last_block;
        end
    end

    assign status.out_free   = out_free;
    assign status.hdr_zero   = {in_byte, bl_reg[23:0]} == '0;
    assign status.last_block = bl_reg == BLOCKS_W'(1);
    assign status.tok_lit    = in_byte[7];
    assign status.tok_empty  = in_byte[LIT_W-1:0] == '0;
    assign status.lit_one    = lit_reg == LIT_W'(1);
    assign status.copy_done  = copy_emit && copy_last;

    assign m_tvalid     = m_valid_reg;
    assign m_data       = m_data_reg;
    assign m_byte_valid = m_bv_reg;
    assign m_run_last   = m_last_reg;
    assign m_stream_end = m_end_reg;

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && mem_re) |-> (wp_reg != src_reg))
        else $error("window read and write hit the same slot");

    a_pend_count: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (cnt_reg != '0))
        else $error("read outstanding with no bytes left to copy");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= (AW+1)'(WINDOW_DEPTH))
        else $error("fill count past window depth");

endmodule

[src/lz_window_decompressor_unit.sv]
// Channel | Dir | tdata         | tuser                        | tlast
// s_      | in  | [7:0] byte    | -                            | -
// m_      | out | [7:0] byte    | [0] byte_valid [1] stream_end | run_last
//
// Header, token and literal bytes are accepted one per cycle while the output register is free.
// A match low byte (length 2..17) starts a copy: after its accept, a registered window RAM
// read, then one byte per cycle through the single read port while the output is free.
// Reset is synchronous; a fill count makes unwritten window slots read as zero, no clear pass.
// While a beat waits and m_tready is low, the output register holds and parsing and copying freeze.
module lz_window_decompressor_unit #(
    parameter int WINDOW_DEPTH = lzwd_pkg::WINDOW_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] stream_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] data_byte
    output logic [1:0] m_tuser,   // [0] byte_valid, [1] stream_end
    output logic       m_tlast
);
    import lzwd_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    byte_valid;
    logic    stream_end;

    lzwd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lzwd_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_byte      (s_tdata),
        .cmd          (cmd),
        .status       (status),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_data       (m_tdata),
        .m_byte_valid (byte_valid),
        .m_run_last   (m_tlast),
        .m_stream_end (stream_end)
    );

    assign m_tuser = {stream_end, byte_valid};

endmodule

[tb/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lzwd_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS = 18;
    localparam int N_DIRECTED = 23;

    localparam logic [2:0] ST_HDR0  = 3'd0;
    localparam logic [2:0] ST_HDR1  = 3'd1;
    localparam logic [2:0] ST_HDR2  = 3'd2;
    localparam logic [2:0] ST_HDR3  = 3'd3;
    localparam logic [2:0] ST_TOKEN = 3'd4;
    localparam logic [2:0] ST_LIT   = 3'd5;
    localparam logic [2:0] ST_MLO   = 3'd6;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
        logic       fin;
    } out_beat_t;

    typedef struct packed {
        logic [7:0] b;
        logic       typed;
        logic [4:0] nres;
        out_beat_t  res;
    } row_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int errors         = 0;
    int items_sent     = 0;
    int stall_cycles   = 0;

    int send_idle_by_phase[4]  = '{0, 79, 0, 12};
    int recv_stall_by_phase[4] = '{0, 0, 79, 12};

    logic [2:0]  stage;
    logic [31:0] blocks_todo;
    logic [6:0]  lits_todo;
    logic [7:0]  match_hi;
    logic [11:0] wr_ptr;
    logic [7:0]  hist_mem[WINDOW_DEPTH_DEF];

    out_beat_t pending_out[$];

    row_t directed_rows[N_DIRECTED] = '{
        '{8'h00, 1'b1, 5'd0, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{8'h00, 1'b1, 5'd0, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{8'h00, 1'b1, 5'd0, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{8'h00, 1'b1, 5'd1, '{8'h00, 1'b0, 1'b1, 1'b1}},
        '{8'h03, 1'b1, 5'd0, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{8'h00, 1'b1, 5'd0, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{8'h00, 1'b1, 5'd0, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{8'h00, 1'b1, 5'd0, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{8'h83, 1'b1, 5'd0, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{8'hff, 1'b1, 5'd1, '{8'hff, 1'b1, 1'b1, 1'b0}},
        '{8'h00, 1'b1, 5'd1, '{8'h00, 1'b1, 1'b1, 1'b0}},
        '{8'ha5, 1'b1, 5'd1, '{8'ha5, 1'b1, 1'b1, 1'b0}},
        '{8'h7f, 1'b1, 5'd0, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{8'hff, 1'b0, 5'd0, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{8'h80, 1'b1, 5'd1, '{8'h00, 1'b0, 1'b1, 1'b1}},
        '{8'h02, 1'b1, 5'd0, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{8'h00, 1'b1, 5'd0, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{8'h00, 1'b1, 5'd0, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{8'h00, 1'b1, 5'd0, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{8'h00, 1'b1, 5'd0, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{8'h00, 1'b0, 5'd0, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{8'h81, 1'b1, 5'd0, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{8'h5a, 1'b1, 5'd1, '{8'h5a, 1'b1, 1'b1, 1'b1}}
    };

    lz_window_decompressor_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    task automatic report_mismatch(input string what);
        errors++;
        $display("%0t ns mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    task automatic store_hist(input logic [7:0] v);
        hist_mem[wr_ptr] = v;
        wr_ptr = wr_ptr + 12'd1;
    endtask

    function automatic logic close_block();
        blocks_todo = blocks_todo - 32'd1;
        if (blocks_todo == 32'd0) begin
            stage = ST_HDR0;
            return 1'b1;
        end
        stage = ST_TOKEN;
        return 1'b0;
    endfunction

    task automatic decode_byte(input logic [7:0] b, output int n, output out_beat_t tail);
        out_beat_t burst[$];
        logic [15:0] word;
        logic [11:0] src;
        logic [7:0] v;
        logic done;
        int len;
        case (stage)
            ST_HDR1, ST_HDR2, ST_HDR3: begin
                blocks_todo[8*stage +: 8] = b;
                if (stage != ST_HDR3) begin
                    stage = stage + 3'd1;
                end else if (blocks_todo != 32'd0) begin
                    stage = ST_TOKEN;
                end else begin
                    stage = ST_HDR0;
                    burst.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
                end
            end
            ST_TOKEN: begin
                if (!b[7]) begin
                    match_hi = b;
                    stage = ST_MLO;
                end else if (b[6:0] != 7'd0) begin
                    lits_todo = b[6:0];
                    stage = ST_LIT;
                end else if (close_block()) begin
                    burst.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
                end
            end
            ST_LIT: begin
                store_hist(b);
                lits_todo = lits_todo - 7'd1;
                done = 1'b0;
                if (lits_todo == 7'd0) begin
                    done = close_block();
                end
                burst.push_back('{b, 1'b1, 1'b1, done});
            end
            ST_MLO: begin
                word = {match_hi, b};
                len = int'(word[15:11]) + LEN_BIAS;
                for (int j = 0; j < len; j++) begin
                    src = wr_ptr - 12'(int'(word[10:0]) + DIST_BIAS);
                    v = hist_mem[src];
                    store_hist(v);
                    done = 1'b0;
                    if (j == len - 1) begin
                        done = close_block();
                    end
                    burst.push_back('{v, 1'b1, logic'(j == len - 1), done});
                end
            end
            default: begin
                blocks_todo = 32'(b);
                stage = ST_HDR1;
            end
        endcase
        n = burst.size();
        tail = '0;
        if (n != 0) begin
            tail = burst[n-1];
        end
        foreach (burst[k]) begin
            pending_out.push_back(burst[k]);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, output int n, output out_beat_t tail);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        items_sent++;
        decode_byte(b, n, tail);
    endtask

    task automatic play_stream();
        int blocks;
        int len;
        int back_off;
        int n;
        out_beat_t tail;
        logic [15:0] word;
        blocks = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
        for (int i = 0; i < 4; i++) begin
            send_byte(8'(blocks >> (8 * i)), n, tail);
        end
        repeat (blocks) begin
            if ($urandom_range(0, 1) == 1) begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 8);
                send_byte(8'h80 | 8'(len), n, tail);
                repeat (len) begin
                    send_byte(8'($urandom), n, tail);
                end
            end else begin
                back_off = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                                       : $urandom_range(0, 24);
                word = {1'b0, 4'($urandom_range(0, 15)), 11'(back_off)};
                send_byte(word[15:8], n, tail);
                send_byte(word[7:0], n, tail);
            end
        end
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_out.size() == 0) begin
                report_mismatch($sformatf("beat %02h with nothing pending", m_tdata));
            end else begin
                want = pending_out.pop_front();
                check_field("data_byte", m_tdata, want.data);
                check_field("byte_valid", m_tuser[0], want.valid);
                check_field("stream_end", m_tuser[1], want.fin);
                check_field("run_last", m_tlast, want.last);
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        int n;
        int target;
        out_beat_t tail;
        stage       = ST_HDR0;
        blocks_todo = '0;
        lits_todo   = '0;
        match_hi    = '0;
        wr_ptr      = '0;
        foreach (hist_mem[i]) begin
            hist_mem[i] = 8'h00;
        end
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].b, n, tail);
            if (directed_rows[i].typed &&
                (n != int'(directed_rows[i].nres) || (n != 0 && tail != directed_rows[i].res))) begin
                report_mismatch($sformatf("directed row %0d decodes to %0d beats", i, n));
            end
        end

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = send_idle_by_phase[p];
            recv_stall_pct = recv_stall_by_phase[p];
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                play_stream();
            end
        end

        repeat (8) begin
            send_byte(8'($urandom), n, tail);
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_out.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[files.f]
src/lzwd_pkg.sv
src/lzwd_ram.sv
src/lzwd_ctrl.sv
src/lzwd_datapath.sv
src/lz_window_decompressor_unit.sv
tb/testbench.sv
